// File: src/lsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_pkg
// Item types, mode and status codes, and saturating helpers for the
// linear sandwich accumulator.
// ----------------------------------------------------------------------------
package lsa_pkg;

  typedef struct packed {
    logic        [2:0]  mode;
    logic        [3:0]  index_a;
    logic        [3:0]  index_b;
    logic signed [31:0] element_value;
    logic signed [31:0] target_value;
    logic               last_in_row;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] read_value;
    logic        [31:0] rows_counted;
    logic        [1:0]  status;
    logic               poisoned_flag;
  } out_item_t;

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_COEF  = 3'd1;
  localparam logic [2:0] MODE_ELEM  = 3'd2;
  localparam logic [2:0] MODE_SCORE = 3'd3;
  localparam logic [2:0] MODE_CROSS = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_INDEX  = 2'd1;
  localparam logic [1:0] ST_POISON = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  // {overflow, saturated sum}
  function automatic logic [64:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    logic        ovf;
    s   = a + b;
    ovf = (a[63] == b[63]) && (s[63] != a[63]);
    if (ovf) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return {ovf, s};
  endfunction

endpackage
`default_nettype wire

// File: src/linear_sandwich_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_sandwich_accumulator
// Cross and score sums for a clustered sandwich variance (linear model),
// built around one shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | signals                        | direction
//  ---------+--------------------------------+----------
//  input    | in_valid, in_ready, in_item    | in
//  output   | out_valid, out_ready, out_item | out
//  config   | cfg_we, cfg_wdata              | in
//
// Loads and non-last elements are handled in the idle state; reads go through a
// read-out state. A last element runs the multiplier through read, multiply and
// accumulate states per product: dot pass, residual, score pass, cross pass, done.
// Reset and clear sweep the score and cross sum memories, with in_ready low.
// in_ready needs the sequencer idle and the output register free or draining.
// ----------------------------------------------------------------------------
module linear_sandwich_accumulator #(
  parameter int MAX_WIDTH = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  lsa_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lsa_pkg::out_item_t   out_item,
  input  wire                  cfg_we,
  input  wire  [4:0]           cfg_wdata
);
  import lsa_pkg::*;

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CXW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH * MAX_WIDTH) : 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int ACCW = 72;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DOT_RD = 4'd2;
  localparam logic [3:0] S_DOT_MU = 4'd3;
  localparam logic [3:0] S_DOT_AC = 4'd4;
  localparam logic [3:0] S_RES    = 4'd5;
  localparam logic [3:0] S_SC_RD  = 4'd6;
  localparam logic [3:0] S_SC_MU  = 4'd7;
  localparam logic [3:0] S_SC_AC  = 4'd8;
  localparam logic [3:0] S_XI_RD  = 4'd9;
  localparam logic [3:0] S_CR_RD  = 4'd10;
  localparam logic [3:0] S_CR_MU  = 4'd11;
  localparam logic [3:0] S_CR_AC  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;
  localparam logic [3:0] S_RDOUT  = 4'd14;

  logic [3:0]  state;
  logic [CXW-1:0] clr_cnt;
  logic [AW-1:0]  ci, cj;
  logic [31:0] rows;
  logic [4:0]  elems;
  logic        poison, sat;
  logic [4:0]  width_reg;
  logic        rd_cross;

  logic signed [31:0] coef_mem [MAX_WIDTH];
  logic signed [31:0] row_mem  [MAX_WIDTH];
  logic [63:0]        score_mem[MAX_WIDTH];
  logic [63:0]        cross_mem[MAX_WIDTH * MAX_WIDTH];
  logic signed [31:0] coef_rd, row_rd;
  logic [63:0]        score_rd, cross_rd;

  logic signed [31:0]     xi, resid;
  logic signed [63:0]     prod;
  logic signed [ACCW-1:0] acc;
  logic signed [31:0]     mul_a, mul_b;

  // ---------------- decode ----------------
  logic          in_fire, out_free, ia_ok, ib_ok, ci_last, cj_last;
  logic [AW-1:0] ia, ib;
  logic [4:0]    elems_new;
  logic [WW-1:0] w_eff;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign ia       = AW'(in_item.index_a);
  assign ib       = AW'(in_item.index_b);
  assign ia_ok    = int'(in_item.index_a) < MAX_WIDTH;
  assign ib_ok    = int'(in_item.index_b) < MAX_WIDTH;
  assign elems_new = (elems == 5'd31) ? elems : elems + 5'd1;

  always_comb begin
    if (width_reg == 5'd0) begin
      w_eff = WW'(1);
    end else if (int'(width_reg) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_reg);
    end
  end

  assign ci_last = int'(ci) == int'(w_eff) - 1;
  assign cj_last = int'(cj) == int'(w_eff) - 1;

  // ---------------- residual from exact dot accumulator ----------------
  logic               fits64, res_sat;
  logic signed [64:0] t65, tsh;
  logic signed [31:0] res_val;

  always_comb begin
    fits64  = (&acc[ACCW-1:63]) || !(|acc[ACCW-1:63]);
    t65     = {acc[63], acc[63:0]} + (65'sd1 <<< (FRAC_BITS - 1));
    tsh     = t65 >>> FRAC_BITS;
    res_sat = 1'b0;
    res_val = tsh[31:0];
    if (!fits64) begin
      res_sat = 1'b1;
      res_val = acc[ACCW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (!((&tsh[64:31]) || !(|tsh[64:31]))) begin
      res_sat = 1'b1;
      res_val = tsh[64] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    mul_a = coef_rd;
    unique case (state)
      S_SC_MU: mul_a = resid;
      S_CR_MU: mul_a = xi;
      default: mul_a = coef_rd;
    endcase
    mul_b = row_rd;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------- memories ----------------
  logic [AW-1:0]  row_raddr, score_raddr;
  logic [CXW-1:0] cross_raddr, pair_addr;
  logic           score_we, cross_we;
  logic [AW-1:0]  score_waddr;
  logic [CXW-1:0] cross_waddr;
  logic [63:0]    score_wdata, cross_wdata;
  logic [64:0]    sum_sc, sum_cr;

  assign pair_addr   = CXW'(int'(ci) * MAX_WIDTH + int'(cj));
  assign row_raddr   = (state == S_CR_RD || state == S_CR_MU || state == S_CR_AC) ? cj : ci;
  assign score_raddr = (state == S_IDLE) ? ia : ci;
  assign cross_raddr = (state == S_IDLE) ? CXW'(int'(ia) * MAX_WIDTH + int'(ib)) : pair_addr;
  assign sum_sc      = sat_add64(score_rd, prod);
  assign sum_cr      = sat_add64(cross_rd, prod);

  always_comb begin
    score_we    = 1'b0;
    score_waddr = ci;
    score_wdata = sum_sc[63:0];
    cross_we    = 1'b0;
    cross_waddr = pair_addr;
    cross_wdata = sum_cr[63:0];
    if (state == S_CLR) begin
      score_we    = int'(clr_cnt) < MAX_WIDTH;
      score_waddr = AW'(clr_cnt);
      score_wdata = '0;
      cross_we    = 1'b1;
      cross_waddr = clr_cnt;
      cross_wdata = '0;
    end else begin
      score_we = (state == S_SC_AC);
      cross_we = (state == S_CR_AC);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_item.mode == MODE_COEF && ia_ok) begin
      coef_mem[ia] <= in_item.element_value;
    end
    coef_rd <= coef_mem[ci];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_item.mode == MODE_ELEM && !poison && ia_ok) begin
      row_mem[ia] <= in_item.element_value;
    end
    row_rd <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[score_waddr] <= score_wdata;
    end
    score_rd <= score_mem[score_raddr];
  end

  always_ff @(posedge clk) begin
    if (cross_we) begin
      cross_mem[cross_waddr] <= cross_wdata;
    end
    cross_rd <= cross_mem[cross_raddr];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      rows      <= '0;
      elems     <= '0;
      poison    <= 1'b0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
      width_reg <= 5'd16;
      ci        <= '0;
      cj        <= '0;
      rd_cross  <= 1'b0;
    end else begin
      if (cfg_we) begin
        width_reg <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + CXW'(1);
          if (clr_cnt == CXW'(MAX_WIDTH * MAX_WIDTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            out_item.read_value    <= '0;
            out_item.rows_counted  <= rows;
            out_item.status        <= ST_OK;
            out_item.poisoned_flag <= poison;
            out_valid              <= 1'b1;
            case (in_item.mode)
              MODE_CLEAR: begin
                rows    <= '0;
                elems   <= '0;
                poison  <= 1'b0;
                sat     <= 1'b0;
                clr_cnt <= '0;
                state   <= S_CLR;
                out_item.rows_counted  <= '0;
                out_item.poisoned_flag <= 1'b0;
              end
              MODE_COEF: begin
                if (!ia_ok) out_item.status <= ST_INDEX;
              end
              MODE_ELEM: begin
                if (poison) begin
                  out_item.status <= ST_POISON;
                end else if (!ia_ok) begin
                  out_item.status <= ST_INDEX;
                end else if (!in_item.last_in_row) begin
                  elems <= elems_new;
                  out_item.status <= sat ? ST_SAT : ST_OK;
                end else if (int'(elems_new) != int'(w_eff)) begin
                  elems  <= '0;
                  poison <= 1'b1;
                  out_item.status        <= ST_POISON;
                  out_item.poisoned_flag <= 1'b1;
                end else begin
                  // full row: run the dot, score and cross passes
                  elems     <= '0;
                  out_valid <= out_valid && !out_ready;
                  acc   <= {{(ACCW-32){in_item.target_value[31]}}, in_item.target_value}
                           <<< FRAC_BITS;
                  ci    <= '0;
                  state <= S_DOT_RD;
                end
              end
              MODE_SCORE, MODE_CROSS: begin
                if (!ia_ok || (in_item.mode == MODE_CROSS && !ib_ok)) begin
                  out_item.status <= ST_INDEX;
                end else begin
                  out_valid <= out_valid && !out_ready;
                  rd_cross  <= (in_item.mode == MODE_CROSS);
                  state     <= S_RDOUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_RDOUT: begin
          if (out_free) begin
            out_item.read_value    <= rd_cross ? cross_rd : score_rd;
            out_item.rows_counted  <= rows;
            out_item.status        <= ST_OK;
            out_item.poisoned_flag <= poison;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DOT_RD: state <= S_DOT_MU;
        S_DOT_MU: state <= S_DOT_AC;
        S_DOT_AC: begin
          acc <= acc - {{(ACCW-64){prod[63]}}, prod};
          ci  <= ci + AW'(1);
          state <= ci_last ? S_RES : S_DOT_RD;
        end
        S_RES: begin
          resid <= res_val;
          if (res_sat) sat <= 1'b1;
          ci    <= '0;
          state <= S_SC_RD;
        end
        S_SC_RD: state <= S_SC_MU;
        S_SC_MU: state <= S_SC_AC;
        S_SC_AC: begin
          if (sum_sc[64]) sat <= 1'b1;
          if (ci_last) begin
            ci    <= '0;
            state <= S_XI_RD;
          end else begin
            ci    <= ci + AW'(1);
            state <= S_SC_RD;
          end
        end
        S_XI_RD: begin
          cj    <= '0;
          state <= S_CR_RD;
        end
        S_CR_RD: begin
          // row_rd still holds x[ci] from the row read
          if (cj == '0) xi <= row_rd;
          state <= S_CR_MU;
        end
        S_CR_MU: state <= S_CR_AC;
        S_CR_AC: begin
          if (sum_cr[64]) sat <= 1'b1;
          if (!cj_last) begin
            cj    <= cj + AW'(1);
            state <= S_CR_RD;
          end else if (!ci_last) begin
            ci    <= ci + AW'(1);
            state <= S_XI_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_item.read_value    <= '0;
            out_item.rows_counted  <= (rows == 32'hffff_ffff) ? rows : rows + 32'd1;
            out_item.status        <= sat ? ST_SAT : ST_OK;
            out_item.poisoned_flag <= poison;
            if (rows != 32'hffff_ffff) rows <= rows + 32'd1;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_no_poison_in_row: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_CLR && state != S_RDOUT) |-> !poison)
    else $error("poisoned while a row is in progress");

  a_clear_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.mode == MODE_CLEAR) |=> (state == S_CLR && rows == '0 && !sat))
    else $error("clear did not restart the sums");

  a_elems_idle_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES) |-> (elems == '0))
    else $error("element count not reset at row end");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    (sat && !(in_fire && in_item.mode == MODE_CLEAR)) |=> sat)
    else $error("saturation mark dropped without clear");

endmodule
`default_nettype wire

// File: tb/lsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_checker
// Watches the item and result channels of the linear sandwich accumulator,
// keeps its own copy of the sums, and compares each result with the oldest
// expected one.
// ----------------------------------------------------------------------------
module lsa_checker
  import lsa_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  input  wire        in_ready,
  input  in_item_t   in_item,
  input  wire        out_valid,
  input  wire        out_ready,
  input  out_item_t  out_item,
  input  wire        cfg_we,
  input  wire  [4:0] cfg_wdata,
  output int         errors,
  output int         pending
);

  localparam int NW = 16;
  localparam int FB = 16;

  logic signed [31:0] coef_mem [NW];
  logic signed [31:0] row_mem  [NW];
  logic signed [63:0] score_acc [NW];
  logic signed [63:0] cross_acc [NW][NW];
  logic        [31:0] row_count;
  int                 elem_count;
  logic               poisoned;
  logic               sat_seen;
  logic        [4:0]  width_reg;
  out_item_t          expected_q [$];

  function automatic logic signed [63:0] add_clamped(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_seen = 1'b1;
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  // target - coef.x, rounded to FB fraction bits and clamped to 32 bits
  function automatic logic signed [31:0] row_residual(logic signed [31:0] tgt, int w);
    logic signed [127:0] acc;
    logic signed [127:0] prod;
    logic signed [63:0]  s;
    logic signed [63:0]  r;
    acc = tgt;
    acc = acc <<< FB;
    for (int i = 0; i < w; i++) begin
      prod = coef_mem[i];
      prod = prod * row_mem[i];
      acc = acc - prod;
    end
    if (acc[127:63] != {65{1'b0}} && acc[127:63] != {65{1'b1}}) begin
      sat_seen = 1'b1;
      return acc[127] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    s = acc[63:0];
    if (s > 64'sh7fff_ffff_ffff_ffff - (64'sd1 <<< (FB - 1))) begin
      sat_seen = 1'b1;
      return 32'sh7fff_ffff;
    end
    r = (s + (64'sd1 <<< (FB - 1))) >>> FB;
    if (r > 64'sh7fff_ffff) begin
      sat_seen = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (r < -64'sh8000_0000) begin
      sat_seen = 1'b1;
      return 32'sh8000_0000;
    end
    return r[31:0];
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t          o;
    int                 w;
    logic signed [31:0] res;
    logic signed [63:0] p;
    o = '0;
    w = (width_reg < 1) ? 1 : (width_reg > NW) ? NW : width_reg;
    case (it.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < NW; i++) begin
          score_acc[i] = '0;
          for (int j = 0; j < NW; j++) cross_acc[i][j] = '0;
        end
        row_count = '0;
        elem_count = 0;
        poisoned = 1'b0;
        sat_seen = 1'b0;
        o.status = ST_OK;
      end
      MODE_COEF: begin
        coef_mem[it.index_a] = it.element_value;
        o.status = ST_OK;
      end
      MODE_ELEM: begin
        if (poisoned) begin
          o.status = ST_POISON;
        end else begin
          row_mem[it.index_a] = it.element_value;
          if (elem_count < 31) elem_count++;
          if (it.last_in_row && elem_count != w) begin
            poisoned = 1'b1;
            elem_count = 0;
            o.status = ST_POISON;
          end else begin
            if (it.last_in_row) begin
              elem_count = 0;
              res = row_residual(it.target_value, w);
              for (int i = 0; i < w; i++) begin
                p = res;
                p = p * row_mem[i];
                score_acc[i] = add_clamped(score_acc[i], p);
              end
              for (int i = 0; i < w; i++) begin
                for (int j = 0; j < w; j++) begin
                  p = row_mem[i];
                  p = p * row_mem[j];
                  cross_acc[i][j] = add_clamped(cross_acc[i][j], p);
                end
              end
              if (row_count != 32'hffff_ffff) row_count++;
            end
            o.status = sat_seen ? ST_SAT : ST_OK;
          end
        end
      end
      MODE_SCORE: o.read_value = score_acc[it.index_a];
      MODE_CROSS: o.read_value = cross_acc[it.index_a][it.index_b];
      default: o.status = ST_OK;
    endcase
    o.rows_counted = row_count;
    o.poisoned_flag = poisoned;
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < NW; i++) begin
        coef_mem[i] = '0;
        row_mem[i] = '0;
        score_acc[i] = '0;
        for (int j = 0; j < NW; j++) cross_acc[i][j] = '0;
      end
      row_count = '0;
      elem_count = 0;
      poisoned = 1'b0;
      sat_seen = 1'b0;
      width_reg = 5'd16;
      expected_q.delete();
      errors = 0;
    end else begin
      if (in_valid && in_ready) expected_q.push_back(apply_item(in_item));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_item);
        end else begin
          want = expected_q.pop_front();
          if (want.read_value !== out_item.read_value ||
              want.rows_counted !== out_item.rows_counted ||
              want.status !== out_item.status ||
              want.poisoned_flag !== out_item.poisoned_flag) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp value %0d rows %0d status %0d poison %0d, ",
                        "got %0d %0d %0d %0d"},
                       want.read_value, want.rows_counted, want.status, want.poisoned_flag,
                       out_item.read_value, out_item.rows_counted, out_item.status,
                       out_item.poisoned_flag);
          end
        end
      end
      if (cfg_we) width_reg = cfg_wdata;
    end
    pending <= expected_q.size();
  end

endmodule

// File: tb/linear_sandwich_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_sandwich_accumulator_tb
// Drives coefficient loads, rows, reads and clears through the accumulator
// under random gaps and output stalls, over a range of row widths.
// ----------------------------------------------------------------------------
module linear_sandwich_accumulator_tb;
  import lsa_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_item;
  logic       cfg_we;
  logic [4:0] cfg_wdata;
  int         errors;
  int         pending;
  int         cycles;
  int         sent;
  int         cur_w;
  logic       quiet;

  linear_sandwich_accumulator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lsa_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int r;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (r < 2) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 50)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= (r >= 25);
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    if (r == 1) return $urandom();
    return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  task automatic send(in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic pause_input();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = quiet ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic op(logic [2:0] m, int a, int b, logic signed [31:0] v,
                    logic signed [31:0] t, logic last);
    in_item_t it;
    it.mode = m;
    it.index_a = a[3:0];
    it.index_b = b[3:0];
    it.element_value = v;
    it.target_value = t;
    it.last_in_row = last;
    send(it);
    pause_input();
  endtask

  // n elements, last flag on the final one; n != cur_w poisons
  task automatic row(int n, bit random_vals);
    int idx;
    for (int k = 0; k < n; k++) begin
      idx = (k < cur_w && (!random_vals || $urandom_range(0, 3) != 0)) ? k :
            $urandom_range(0, 15);
      op(MODE_ELEM, idx, $urandom_range(0, 15),
         random_vals ? pick_value() : 32'sh0001_0000 * (k + 1),
         pick_value(), k == n - 1);
    end
  endtask

  task automatic set_width(logic [4:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_w = (v < 1) ? 1 : (v > 16) ? 16 : v;
  endtask

  task automatic random_phase(int count);
    int r;
    int n;
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        row(cur_w, 1);
      end else if (r < 73) begin
        do n = $urandom_range(1, 20); while (n == cur_w);
        row(n, 1);
        repeat ($urandom_range(0, 2))
          op(MODE_ELEM, $urandom_range(0, 15), 0, pick_value(), pick_value(),
             1'($urandom_range(0, 1)));
        op(MODE_SCORE, $urandom_range(0, 15), 0, pick_value(), 0, 0);
        op(MODE_CLEAR, 0, 0, pick_value(), pick_value(), 1'($urandom_range(0, 1)));
      end else if (r < 85) begin
        op(MODE_SCORE, $urandom_range(0, 15), $urandom_range(0, 15), pick_value(),
           pick_value(), 1'($urandom_range(0, 1)));
        op(MODE_CROSS, $urandom_range(0, 15), $urandom_range(0, 15), pick_value(),
           pick_value(), 1'($urandom_range(0, 1)));
      end else if (r < 93) begin
        op(MODE_COEF, $urandom_range(0, 15), $urandom_range(0, 15), pick_value(),
           pick_value(), 1'($urandom_range(0, 1)));
      end else if (r < 96) begin
        op(MODE_CLEAR, 0, 0, 0, 0, 0);
      end else begin
        op(3'($urandom_range(5, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
           pick_value(), pick_value(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    logic [4:0] widths [7] = '{5'd1, 5'd31, 5'd0, 5'd5, 5'd16, 5'd3, 5'd9};
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = 5'd16;
    quiet = 1'b0;
    sent = 0;
    cur_w = 16;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every coefficient written before any row; the first row writes every buffer entry
    for (int i = 0; i < 16; i++)
      op(MODE_COEF, i, 0, (i == 0) ? 32'sh7fff_ffff : (i == 1) ? 32'sh8000_0000 :
         32'sh0000_8000 * i, 0, 0);
    row(16, 0);
    op(MODE_SCORE, 0, 0, 0, 0, 0);
    op(MODE_CROSS, 15, 15, 0, 0, 1);
    op(3'd5, 15, 15, 32'shffff_ffff, 32'shffff_ffff, 1);
    op(3'd7, 0, 0, 0, 0, 0);
    // extreme row drives residual and sums into saturation
    for (int k = 0; k < 16; k++)
      op(MODE_ELEM, k, 0, 32'sh8000_0000, 32'sh7fff_ffff, k == 15);
    row(3, 0);
    op(MODE_ELEM, 2, 0, 32'sh1234_5678, 0, 1);
    op(MODE_CROSS, 0, 0, 0, 0, 0);
    op(MODE_CLEAR, 0, 0, 0, 0, 0);

    quiet = 1'b1;
    random_phase(60);
    quiet = 1'b0;
    random_phase(60);
    foreach (widths[p]) begin
      set_width(widths[p]);
      quiet = (p == 3);
      random_phase(100);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
